// File: rtl/core/power_iteration_eigenvector_core_macros.svh
// Assertion macros shared by the power iteration core.
`ifndef POWER_ITERATION_EIGENVECTOR_CORE_MACROS_SVH
`define POWER_ITERATION_EIGENVECTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PIE_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("power iteration core: assertion failed");
`define PIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("power iteration core: assertion failed");
`else
`define PIE_ASSERT(lbl, clk, rstn, prop)
`define PIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/pie_pkg.sv
// Types, codes and helper functions of the power iteration core.
package pie_pkg;

	localparam int DEFAULT_MAX_SIZE = 16;
	localparam int SIZE_CAP = 16;
	localparam int CNT_W = 5;
	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS = 48;

	localparam logic [1:0] KIND_MATRIX = 2'd0;
	localparam logic [1:0] KIND_VECTOR = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [1:0] STATUS_CONV = 2'd0;
	localparam logic [1:0] STATUS_LIMIT = 2'd1;
	localparam logic [1:0] STATUS_ZERO = 2'd2;

	localparam logic [1:0] REG_SIZE = 2'd0;
	localparam logic [1:0] REG_TOL = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam logic [4:0] SIZE_RESET = 5'd4;
	localparam logic [30:0] TOL_RESET = 31'd66;
	localparam logic [15:0] LIMIT_RESET = 16'd100;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_ROOT_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_COPY,
		ST_MV,
		ST_LOADP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic shift;
		logic shift_prd;
		logic copy;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic signed [31:0] cur;
		logic signed [31:0] prv;
		logic signed [31:0] prd;
	} cell_data_t;

	function automatic logic signed [31:0] sat_mag(input logic [47:0] mag, input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			r = (mag >= 48'h0000_8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
		end else begin
			r = (mag > 48'h0000_7fff_ffff) ? 32'sh7fff_ffff : $signed(mag[31:0]);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/pie_cell.sv
// One cell of the vector chain: current, previous and product elements.
module pie_cell (
	input  logic                clk,
	input  pie_pkg::cell_ctl_t  ctl,
	input  logic                active,
	input  logic                tail,
	input  logic                wr,
	input  logic signed [31:0]  wr_data,
	input  pie_pkg::cell_data_t nxt,
	input  pie_pkg::cell_data_t ins,
	output pie_pkg::cell_data_t q
);
	import pie_pkg::*;

	cell_data_t data_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			data_q.cur <= wr_data;
		end else if (ctl.load) begin
			data_q.cur <= data_q.prd;
		end else if (ctl.shift && active) begin
			data_q.cur <= tail ? ins.cur : nxt.cur;
		end
		if (ctl.copy) begin
			data_q.prv <= data_q.cur;
		end else if (ctl.shift && active) begin
			data_q.prv <= tail ? ins.prv : nxt.prv;
		end
		if (ctl.shift_prd && active) begin
			data_q.prd <= tail ? ins.prd : nxt.prd;
		end
	end

	assign q = data_q;

endmodule

// File: rtl/core/pie_root.sv
// Iterative integer square root, two radicand bits a cycle.
module pie_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        busy,
	output logic        done,
	output logic [31:0] root
);
	import pie_pkg::*;

	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [35:0] r2;
	logic [35:0] trial;
	logic [35:0] diff;
	logic        ge;

	assign r2 = {rem_q, x_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff = r2 - trial;
	assign ge = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(ROOT_STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			rem_q <= '0;
			root_q <= '0;
		end else if (run_q) begin
			x_q <= {x_q[61:0], 2'b00};
			rem_q <= ge ? diff[33:0] : r2[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/core/pie_div.sv
// Iterative restoring divider, one quotient bit a cycle.
module pie_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [47:0] quotient
);
	import pie_pkg::*;

	logic [47:0] dq_q;
	logic [31:0] rem_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] r2;
	logic [32:0] diff;
	logic        ge;

	assign r2 = {rem_q, dq_q[47]};
	assign diff = r2 - {1'b0, d_q};
	assign ge = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rem_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			dq_q <= {dq_q[46:0], ge};
			rem_q <= ge ? diff[31:0] : r2[31:0];
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quotient = dq_q;

endmodule

// File: rtl/core/power_iteration_eigenvector_core.sv
// Top level of the power iteration core: sequencer, matrix memory and cell chain.
//
// Input words are taken when start is high and busy is low. Kind 0 writes one
// matrix element and kind 1 one start vector element; for both, busy stays
// low. Kind 2 starts a run, and busy stays high until it ends.
// Configuration words arrive on the cfg channel, which is always ready.
// A run normalises the vector, then repeats multiply, normalise and distance.
// Each normalisation pass takes the norm through the square root and then
// divides every element by it in the serial divider; the multiply streams
// the matrix memory at one element a cycle, and the distance uses the square
// root again; the serial divider takes most of the time of a run.
// At the end n result words leave on consecutive cycles, each marked by
// strobe for one cycle, with last on the final one; the receiver cannot stall.
// Reset returns the registers to their defaults and the sequencer to idle;
// the matrix memory and the vector cells hold undefined data until written.
`include "power_iteration_eigenvector_core_macros.svh"
module power_iteration_eigenvector_core #(
	parameter int MAX_SIZE = pie_pkg::DEFAULT_MAX_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [3:0]         row,
	input  logic [3:0]         column,
	input  logic signed [31:0] value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               strobe,
	output logic [3:0]         index,
	output logic signed [31:0] element,
	output logic [15:0]        iterations,
	output logic [1:0]         status,
	output logic               last
);
	import pie_pkg::*;

	localparam int CAP = (MAX_SIZE < SIZE_CAP) ? MAX_SIZE : SIZE_CAP;
	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t st_q, st_d;
	logic [4:0]  ms_q;
	logic [30:0] tol_q;
	logic [15:0] lim_q;
	logic [CNT_W-1:0] n_q, cnt_q, k_q, l_q;
	logic        dist_q, init_q;
	logic [15:0] iters_q;
	logic [1:0]  status_q;
	logic        strobe_q;
	logic [3:0]  index_q;
	logic signed [31:0] element_q;
	logic        last_q;

	logic accept, mwr, vwr, acc_issue, mv_issue, emit, root_start, div_start;
	cell_ctl_t ctl;
	cell_data_t cq [MAX_SIZE];
	cell_data_t ins;
	logic [CNT_W-1:0] n_sel;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] mrd_s1, cur0_s1;
	logic signed [63:0] prod_s2, acc_q, fin_s3;
	logic mv_s1, mv_s2, mlast_s1, mlast_s2, fv_s3;
	logic [31:0] sqm_s1;
	logic [63:0] sq_s2, sum_q;
	logic sv_s1, sv_s2;
	logic [31:0] norm_q;

	logic root_busy, root_done, div_busy, div_done;
	logic [31:0] root_val;
	logic [47:0] quo;
	logic signed [32:0] diff33;
	logic [32:0] mag33;
	logic [31:0] mag_cur;
	logic [47:0] dvd;
	logic signed [31:0] qsat, rsat;
	logic [63:0] fmag, rsum;
	logic [64:0] sadd;
	logic [AW-1:0] waddr, raddr;
	logic cnt_last;

	assign accept = start && !busy;
	assign busy = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign mwr = accept && (kind == KIND_MATRIX) && (32'(row) < MAX_SIZE)
		&& (32'(column) < MAX_SIZE);
	assign vwr = accept && (kind == KIND_VECTOR) && (32'(row) < MAX_SIZE);
	assign waddr = AW'(32'(row) * MAX_SIZE + 32'(column));
	assign raddr = AW'(32'(k_q) * MAX_SIZE + 32'(l_q));
	assign cnt_last = (cnt_q == n_q - 5'd1);

	always_comb begin
		if (ms_q == 5'd0) begin
			n_sel = 5'd1;
		end else if (32'(ms_q) > CAP) begin
			n_sel = 5'(CAP);
		end else begin
			n_sel = ms_q;
		end
	end

	assign diff33 = {cq[0].cur[31], cq[0].cur} - (dist_q ? {cq[0].prv[31], cq[0].prv} : 33'sd0);
	assign mag33 = diff33[32] ? 33'(-diff33) : 33'(diff33);
	assign mag_cur = cq[0].cur[31] ? 32'(-{cq[0].cur[31], cq[0].cur}) : 32'(cq[0].cur);
	assign dvd = {mag_cur, 16'h0000} + 48'(norm_q >> 1);
	assign qsat = sat_mag(quo, cq[0].cur[31]);
	assign fmag = fin_s3[63] ? 64'(-fin_s3) : 64'(fin_s3);
	assign rsum = fmag + 64'd32768;
	assign rsat = sat_mag(rsum[63:16], fin_s3[63]);
	assign sadd = {1'b0, sum_q} + {1'b0, sq_s2};

	assign ins.cur = (st_q == ST_DIV_WAIT) ? qsat : cq[0].cur;
	assign ins.prv = cq[0].prv;
	assign ins.prd = rsat;

	always_comb begin
		st_d = st_q;
		ctl = '0;
		root_start = 1'b0;
		div_start = 1'b0;
		acc_issue = 1'b0;
		mv_issue = 1'b0;
		emit = 1'b0;
		ctl.shift_prd = fv_s3;
		unique case (st_q)
			ST_IDLE: begin
				if (accept && kind == KIND_START) st_d = ST_ACC;
			end
			ST_ACC: begin
				if (cnt_q < n_q) begin
					acc_issue = 1'b1;
					ctl.shift = 1'b1;
				end else if (!sv_s1 && !sv_s2) begin
					root_start = 1'b1;
					st_d = ST_ROOT_WAIT;
				end
			end
			ST_ROOT_WAIT: begin
				if (root_done) begin
					if (!dist_q) begin
						st_d = (root_val == 32'd0) ? ST_EMIT : ST_DIV_GO;
					end else if (root_val < {1'b0, tol_q} || iters_q == lim_q) begin
						st_d = ST_EMIT;
					end else begin
						st_d = ST_COPY;
					end
				end
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				st_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					ctl.shift = 1'b1;
					if (cnt_last) begin
						if (init_q) begin
							st_d = (lim_q == 16'd0) ? ST_EMIT : ST_COPY;
						end else begin
							st_d = ST_ACC;
						end
					end else begin
						st_d = ST_DIV_GO;
					end
				end
			end
			ST_COPY: begin
				ctl.copy = 1'b1;
				st_d = ST_MV;
			end
			ST_MV: begin
				if (k_q < n_q) begin
					mv_issue = 1'b1;
					ctl.shift = 1'b1;
				end else if (!mv_s1 && !mv_s2 && !fv_s3) begin
					st_d = ST_LOADP;
				end
			end
			ST_LOADP: begin
				ctl.load = 1'b1;
				st_d = ST_ACC;
			end
			ST_EMIT: begin
				emit = 1'b1;
				ctl.shift = 1'b1;
				if (cnt_last) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ms_q <= SIZE_RESET;
			tol_q <= TOL_RESET;
			lim_q <= LIMIT_RESET;
			n_q <= 5'd1;
			cnt_q <= '0;
			k_q <= '0;
			l_q <= '0;
			dist_q <= 1'b0;
			init_q <= 1'b0;
			iters_q <= '0;
			status_q <= STATUS_LIMIT;
			strobe_q <= 1'b0;
			sv_s1 <= 1'b0;
			sv_s2 <= 1'b0;
			mv_s1 <= 1'b0;
			mv_s2 <= 1'b0;
			mlast_s1 <= 1'b0;
			mlast_s2 <= 1'b0;
			fv_s3 <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SIZE: ms_q <= cfg_data[4:0];
					REG_TOL: tol_q <= cfg_data[30:0];
					REG_LIMIT: lim_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if ((st_d != st_q && (st_d == ST_ACC || st_d == ST_EMIT))
				|| (st_q == ST_ROOT_WAIT && st_d == ST_DIV_GO)) begin
				cnt_q <= '0;
			end else if (acc_issue || emit || (st_q == ST_DIV_WAIT && div_done)) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (st_q == ST_COPY) begin
				k_q <= '0;
				l_q <= '0;
			end else if (mv_issue) begin
				if (l_q == n_q - 5'd1) begin
					l_q <= '0;
					k_q <= k_q + 5'd1;
				end else begin
					l_q <= l_q + 5'd1;
				end
			end
			if (st_q == ST_IDLE && st_d == ST_ACC) begin
				n_q <= n_sel;
				dist_q <= 1'b0;
				init_q <= 1'b1;
				iters_q <= '0;
				status_q <= STATUS_LIMIT;
			end
			if (st_q == ST_DIV_WAIT && div_done && cnt_last) begin
				init_q <= 1'b0;
				if (!init_q) dist_q <= 1'b1;
			end
			if (st_q == ST_LOADP) dist_q <= 1'b0;
			if (st_d == ST_COPY) begin
				iters_q <= (st_q == ST_DIV_WAIT) ? 16'd1 : iters_q + 16'd1;
			end
			if (st_q == ST_ROOT_WAIT && root_done) begin
				if (!dist_q && root_val == 32'd0) begin
					status_q <= STATUS_ZERO;
				end else if (dist_q && root_val < {1'b0, tol_q}) begin
					status_q <= STATUS_CONV;
				end
			end
			strobe_q <= emit;
			sv_s1 <= acc_issue;
			sv_s2 <= sv_s1;
			mv_s1 <= mv_issue;
			mlast_s1 <= (l_q == n_q - 5'd1);
			mv_s2 <= mv_s1;
			mlast_s2 <= mlast_s1;
			fv_s3 <= mv_s2 && mlast_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mwr) mem[waddr] <= value;
		if (mv_issue) mrd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		cur0_s1 <= cq[0].cur;
		prod_s2 <= mrd_s1 * cur0_s1;
		sqm_s1 <= mag33[31:0];
		sq_s2 <= sqm_s1 * sqm_s1;
		if (st_d == ST_ACC && st_q != ST_ACC) begin
			sum_q <= '0;
		end else if (sv_s2) begin
			sum_q <= sadd[64] ? '1 : sadd[63:0];
		end
		if (st_q == ST_COPY) begin
			acc_q <= '0;
		end else if (mv_s2) begin
			if (mlast_s2) begin
				fin_s3 <= acc_q + prod_s2;
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + prod_s2;
			end
		end
		if (st_q == ST_ROOT_WAIT && root_done) norm_q <= root_val;
		if (emit) begin
			index_q <= cnt_q[3:0];
			element_q <= cq[0].cur;
			last_q <= cnt_last;
		end
	end

	for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
		cell_data_t nxt;
		if (i == MAX_SIZE - 1) begin : g_end
			assign nxt = cq[i];
		end else begin : g_mid
			assign nxt = cq[i+1];
		end
		pie_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.active  (32'(n_q) > i),
			.tail    (32'(n_q) == i + 1),
			.wr      (vwr && (32'(row) == i)),
			.wr_data (value),
			.nxt     (nxt),
			.ins     (ins),
			.q       (cq[i])
		);
	end

	pie_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.x      (sum_q),
		.busy   (root_busy),
		.done   (root_done),
		.root   (root_val)
	);

	pie_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (norm_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	assign strobe = strobe_q;
	assign index = index_q;
	assign element = element_q;
	assign iterations = iters_q;
	assign status = status_q;
	assign last = last_q;

	`PIE_ASSERT(a_strobe_from_emit, clk, arst_n, strobe |-> $past(st_q == ST_EMIT))
	`PIE_ASSERT(a_root_free, clk, arst_n, root_start |-> !root_busy)
	`PIE_ASSERT(a_div_free, clk, arst_n, div_start |-> !div_busy)
	`PIE_ASSERT_NEXT(a_last_ends, clk, arst_n, strobe && last, !strobe)

endmodule

// File: verif/tb_power_iteration_eigenvector_core.sv
// Self-checking testbench of the power iteration core with a built-in eigenvector predictor.
`timescale 1ns / 100ps
module tb_power_iteration_eigenvector_core;
	import pie_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEM_TARGET = 190;

	typedef struct {
		logic [3:0]         idx;
		logic signed [31:0] elem;
		logic [15:0]        iters;
		logic [1:0]         stat;
		logic               fin;
	} eig_word_t;

	class eigvec_scoreboard;
		logic [4:0]         size_reg;
		logic [30:0]        tol_reg;
		logic [15:0]        limit_reg;
		logic signed [31:0] mat [16][16];
		logic signed [31:0] cur [16];
		logic signed [31:0] prv [16];
		logic signed [31:0] prd [16];
		eig_word_t          expected_q[$];
		int                 errors;

		function void reset_regs();
			size_reg = SIZE_RESET;
			tol_reg = TOL_RESET;
			limit_reg = LIMIT_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
				REG_SIZE: size_reg = data[4:0];
				REG_TOL: tol_reg = data[30:0];
				REG_LIMIT: limit_reg = data[15:0];
				default: ;
			endcase
		endfunction

		function longint unsigned int_root(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x)
				b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function logic signed [31:0] clamp_mag(longint unsigned mag, bit neg);
			if (neg)
				return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
			return (mag > 64'h7fff_ffff) ? 32'sh7fff_ffff : $signed(mag[31:0]);
		endfunction

		// Root of the sum of squares of cur, or of cur minus prv.
		function longint unsigned euclid(int n, bit diff);
			longint unsigned s, m, sq;
			longint d;
			s = 0;
			for (int j = 0; j < n; j++) begin
				d = longint'(cur[j]) - (diff ? longint'(prv[j]) : 64'sd0);
				m = (d < 0) ? -d : d;
				sq = m * m;
				s = (s > 64'hffff_ffff_ffff_ffff - sq) ? 64'hffff_ffff_ffff_ffff : s + sq;
			end
			return int_root(s);
		endfunction

		function void normalise(int n, longint unsigned nrm);
			longint unsigned m, q;
			longint d;
			for (int j = 0; j < n; j++) begin
				d = cur[j];
				m = (d < 0) ? -d : d;
				q = ((m << 16) + nrm / 2) / nrm;
				cur[j] = clamp_mag(q, d < 0);
			end
		endfunction

		function void multiply(int n);
			longint acc;
			longint unsigned m;
			for (int k = 0; k < n; k++) begin
				acc = 0;
				for (int l = 0; l < n; l++)
					acc += longint'(mat[k][l]) * longint'(cur[l]);
				m = (((acc < 0) ? -acc : acc) + 32768) >> 16;
				prd[k] = clamp_mag(m, acc < 0);
			end
		endfunction

		function void run_iterations();
			int n;
			int unsigned iters;
			logic [1:0] stat;
			longint unsigned nrm;
			eig_word_t w;
			n = (size_reg == 0) ? 1 : size_reg;
			if (n > 16)
				n = 16;
			iters = 0;
			stat = STATUS_LIMIT;
			nrm = euclid(n, 0);
			if (nrm == 0) begin
				stat = STATUS_ZERO;
			end else begin
				normalise(n, nrm);
				for (int i = 1; i <= limit_reg; i++) begin
					iters = i;
					prv = cur;
					multiply(n);
					cur = prd;
					nrm = euclid(n, 0);
					if (nrm == 0) begin
						stat = STATUS_ZERO;
						break;
					end
					normalise(n, nrm);
					if (euclid(n, 1) < tol_reg) begin
						stat = STATUS_CONV;
						break;
					end
				end
			end
			for (int j = 0; j < n; j++) begin
				w.idx = 4'(j);
				w.elem = cur[j];
				w.iters = iters[15:0];
				w.stat = stat;
				w.fin = (j == n - 1);
				expected_q.push_back(w);
			end
		endfunction

		function void note_item(logic [1:0] k, logic [3:0] r, logic [3:0] c,
				logic signed [31:0] v);
			case (k)
				KIND_MATRIX: mat[r][c] = v;
				KIND_VECTOR: cur[r] = v;
				KIND_START: run_iterations();
				default: ;
			endcase
		endfunction

		function void check_word(logic [3:0] idx, logic signed [31:0] elem,
				logic [15:0] iters, logic [1:0] stat, logic fin);
			eig_word_t w;
			if (expected_q.size() == 0) begin
				$error("unexpected result word, index %0d element %0d", idx, elem);
				errors++;
				return;
			end
			w = expected_q.pop_front();
			if (idx !== w.idx) begin
				$error("index expected %0d actual %0d", w.idx, idx);
				errors++;
			end
			if (elem !== w.elem) begin
				$error("element expected %0d actual %0d", w.elem, elem);
				errors++;
			end
			if (iters !== w.iters) begin
				$error("iterations expected %0d actual %0d", w.iters, iters);
				errors++;
			end
			if (stat !== w.stat) begin
				$error("status expected %0d actual %0d", w.stat, stat);
				errors++;
			end
			if (fin !== w.fin) begin
				$error("last expected %0d actual %0d", w.fin, fin);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         kind;
	logic [3:0]         row;
	logic [3:0]         column;
	logic signed [31:0] value;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               strobe;
	logic [3:0]         index;
	logic signed [31:0] element;
	logic [15:0]        iterations;
	logic [1:0]         status;
	logic               last;

	eigvec_scoreboard sb;
	int  idle_cycles;
	int  sent_items;
	bit  burst;
	bit  mat_ok [16][16];
	bit  vec_ok [16];

	power_iteration_eigenvector_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .row(row), .column(column), .value(value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .strobe(strobe), .index(index), .element(element),
		.iterations(iterations), .status(status), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_word(index, element, iterations, status, last);
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'd0;
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	task automatic send_word(input logic [1:0] k, input logic [3:0] r,
			input logic [3:0] c, input logic [31:0] v);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		row <= r;
		column <= c;
		value <= v;
		do @(posedge clk); while (busy);
		sb.note_item(k, r, c, v);
		sent_items++;
		if (k == KIND_MATRIX)
			mat_ok[r][c] = 1'b1;
		else if (k == KIND_VECTOR)
			vec_ok[r] = 1'b1;
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [4:0] sz, input logic [30:0] tol,
			input logic [15:0] lim);
		drain();
		write_cfg(REG_LIMIT, {16'd0, lim});
		write_cfg(REG_SIZE, {27'd0, sz});
		write_cfg(REG_TOL, {1'b0, tol});
		cfg_valid <= 1'b0;
	endtask

	// Fills every entry a run of size n reads, rewrites some, adds noise, then starts.
	task automatic load_and_run(input int n);
		bit zero_mat, zero_vec, dominant;
		logic [31:0] v;
		zero_mat = ($urandom_range(0, 11) == 0);
		zero_vec = ($urandom_range(0, 9) == 0);
		dominant = ($urandom_range(0, 1) == 0);
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				if (!mat_ok[r][c] || zero_mat || $urandom_range(0, 3) == 0) begin
					v = zero_mat ? 32'd0 : rand_value();
					if (dominant && r == c && !zero_mat)
						v = v + 32'h0008_0000;
					send_word(KIND_MATRIX, 4'(r), 4'(c), v);
				end
		for (int j = 0; j < n; j++)
			if (!vec_ok[j] || zero_vec || $urandom_range(0, 2) == 0)
				send_word(KIND_VECTOR, 4'(j), 4'($urandom),
					zero_vec ? 32'd0 : rand_value());
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 2))
				0: send_word(KIND_UNUSED, 4'($urandom), 4'($urandom), $urandom);
				1: send_word(KIND_MATRIX, 4'($urandom), 4'($urandom), rand_value());
				default: send_word(KIND_VECTOR, 4'($urandom), 4'($urandom), rand_value());
			endcase
		end
		send_word(KIND_START, 4'($urandom), 4'($urandom), $urandom);
		for (int j = n; j < 16; j++)
			vec_ok[j] = 1'b0;
		if ($urandom_range(0, 4) == 0)
			drain();
	endtask

	initial begin
		int sz, n, lim;
		logic [30:0] tol;
		sb = new();
		sb.reset_regs();
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_MATRIX;
		row = '0;
		column = '0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SIZE;
		cfg_data = '0;
		idle_cycles = 0;
		sent_items = 0;
		burst = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				send_word(KIND_MATRIX, 4'(r), 4'(c),
					(r == c) ? 32'h0002_0000 : 32'h0000_4000);
		send_word(KIND_VECTOR, 0, 0, 32'h7fff_ffff);
		send_word(KIND_VECTOR, 1, 0, 32'h8000_0000);
		send_word(KIND_VECTOR, 2, 15, 32'h0001_0000);
		send_word(KIND_VECTOR, 3, 15, 32'hffff_ffff);
		send_word(KIND_UNUSED, 15, 15, 32'hffff_ffff);
		send_word(KIND_START, 0, 0, 32'd0);
		send_word(KIND_START, 15, 15, 32'hffff_ffff);
		configure(5'd0, 31'd0, 16'd0);
		send_word(KIND_VECTOR, 0, 0, 32'h0003_0000);
		send_word(KIND_START, 0, 0, 32'd0);
		send_word(KIND_VECTOR, 0, 0, 32'd0);
		send_word(KIND_START, 0, 0, 32'd0);
		configure(5'd1, 31'd100, 16'd5);
		send_word(KIND_MATRIX, 0, 0, 32'd0);
		send_word(KIND_VECTOR, 0, 0, 32'h0001_0000);
		send_word(KIND_START, 0, 0, 32'd0);

		while (sent_items < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: sz = 0;
				1, 2: sz = $urandom_range(5, 8);
				default: sz = $urandom_range(1, 4);
			endcase
			n = (sz == 0) ? 1 : (sz > 16 ? 16 : sz);
			lim = (n > 8) ? $urandom_range(1, 3) : $urandom_range(1, 10);
			if ($urandom_range(0, 7) == 0)
				lim = 0;
			case ($urandom_range(0, 4))
				0: tol = 31'd0;
				1: tol = 31'h7fff_ffff;
				2: tol = 31'($urandom_range(0, 31'h7fff_ffff));
				default: tol = 31'($urandom_range(0, 2000));
			endcase
			configure(5'(sz), tol, 16'(lim));
			burst = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3))
				load_and_run(n);
		end

		configure(5'd4, 31'h7fff_ffff, 16'hffff);
		burst = 1'b0;
		load_and_run(4);
		configure(5'd4, 31'd1, 16'd1);
		load_and_run(4);
		drain();

		if (sb.expected_q.size() != 0) begin
			$error("%0d expected result words never arrived", sb.expected_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
